FILE: rtl/tet_pkg.sv
// shared types, constants and arithmetic helpers for the twist exponential block
`timescale 1ns / 1ps
package tet_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ANG_BITS     = 30;

  // angle constants at 30 fraction bits
  localparam logic signed [35:0] PI_A      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_A  = 36'sd6746518852;
  localparam logic signed [35:0] HALF_PI_A = 36'sd1686629713;
  localparam logic signed [35:0] GAIN_A    = 36'sd652032874;
  localparam logic signed [35:0] X_START   =
    GAIN_A + ((GAIN_A * 2 / 3) >>> (2 * CORDIC_STEPS));

  // 2^32 / 2pi rounded, turns of a fixed-point angle after a shift by 32 + FRAC_BITS
  localparam logic signed [31:0] RECIP_2PI = 32'sd683565276;

  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_W_X = 3'd0, REG_W_Y = 3'd1, REG_W_Z = 3'd2,
    REG_V_X = 3'd3, REG_V_Y = 3'd4, REG_V_Z = 3'd5
  } reg_idx_t;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    q_t wx, wy, wz, vx, vy, vz;
  } twist_t;

  typedef struct packed {
    q_t sn;
    q_t cs;
    q_t th;
  } trig_t;

  // arctangent table, truncated at 30 fraction bits
  function automatic logic signed [35:0] atan_a(input logic [4:0] i);
    logic signed [35:0] r;
    begin
      case (i)
        5'd0:  r = 36'h03243F6A8;
        5'd1:  r = 36'h01DAC6705;
        5'd2:  r = 36'h00FADBAFC;
        5'd3:  r = 36'h007F56EA6;
        5'd4:  r = 36'h003FEAB76;
        5'd5:  r = 36'h001FFD55B;
        5'd6:  r = 36'h000FFFAAA;
        5'd7:  r = 36'h0007FFF55;
        5'd8:  r = 36'h0003FFFEA;
        5'd9:  r = 36'h0001FFFFD;
        5'd10: r = 36'h0000FFFFF;
        5'd11: r = 36'h00007FFFF;
        5'd12: r = 36'h00003FFFF;
        5'd13: r = 36'h00001FFFF;
        5'd14: r = 36'h00000FFFF;
        5'd15: r = 36'h000007FFF;
        5'd16: r = 36'h000003FFF;
        5'd17: r = 36'h000001FFF;
        5'd18: r = 36'h000000FFF;
        5'd19: r = 36'h0000007FF;
        5'd20: r = 36'h0000003FF;
        5'd21: r = 36'h0000001FF;
        5'd22: r = 36'h0000000FF;
        5'd23: r = 36'h00000007F;
        5'd24: r = 36'h00000003F;
        5'd25: r = 36'h00000001F;
        5'd26: r = 36'h00000000F;
        5'd27: r = 36'h000000008;
        5'd28: r = 36'h000000004;
        5'd29: r = 36'h000000002;
        5'd30: r = 36'h000000001;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // saturate a wide signed sum to 32 bits
  function automatic q_t sat32(input logic signed [39:0] v);
    begin
      if (v > 40'sh007FFFFFFF) return 32'sh7FFFFFFF;
      else if (v < -40'sh0080000000) return 32'sh80000000;
      else return v[31:0];
    end
  endfunction

  // round half up and saturate a Q product
  function automatic q_t mulq(input q_t a, input q_t b);
    logic signed [63:0] p;
    logic signed [63:0] s;
    begin
      p = a * b;
      s = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (s > 64'sh000000007FFFFFFF) return 32'sh7FFFFFFF;
      else if (s < -64'sh0000000080000000) return 32'sh80000000;
      else return s[31:0];
    end
  endfunction

endpackage

FILE: rtl/tet_cordic.sv
// angle reduction and pipelined cordic sine and cosine, one step per stage
`timescale 1ns / 1ps
module tet_cordic
  import tet_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  q_t    theta,
  output logic  out_vld,
  output trig_t out_trig
);

  localparam int NS  = CORDIC_STEPS + 4;
  localparam int QSH = 32 + FRAC_BITS;

  logic               vld_r [NS];
  logic signed [35:0] x_r   [NS];
  logic signed [35:0] y_r   [NS];
  logic signed [35:0] z_r   [NS];
  logic               neg_r [NS];
  q_t                 th_r  [NS];
  logic signed [62-QSH:0] q_r;

  // stage 0: nearest whole number of turns by reciprocal multiplication
  logic signed [62:0] qprod;
  logic signed [62:0] qsum;
  assign qprod = theta * RECIP_2PI;
  assign qsum  = qprod + (63'sd1 <<< (QSH - 1));

  // stage 1: remainder after removing whole turns, lands just around +-pi
  logic signed [51:0] rem_w;
  assign rem_w = (52'(th_r[0]) <<< (ANG_BITS - FRAC_BITS)) - q_r * TWO_PI_A;

  // stage 2: wrap into +-pi, then fold into +-pi/2
  logic signed [35:0] zw;
  logic signed [35:0] z_red;
  logic               neg_red;
  always_comb begin
    zw = z_r[1];
    if (zw > PI_A) zw = zw - TWO_PI_A;
    if (zw < -PI_A) zw = zw + TWO_PI_A;
    neg_red = 1'b0;
    z_red = zw;
    if (zw > HALF_PI_A) begin
      z_red = zw - PI_A;
      neg_red = 1'b1;
    end else if (zw < -HALF_PI_A) begin
      z_red = zw + PI_A;
      neg_red = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < NS; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r      <= qsum[62:QSH];
      th_r[0]  <= theta;
      z_r[1]   <= rem_w[35:0];
      th_r[1]  <= th_r[0];
      x_r[2]   <= X_START;
      y_r[2]   <= '0;
      z_r[2]   <= z_red;
      neg_r[2] <= neg_red;
      th_r[2]  <= th_r[1];
      // one rotation per stage
      for (int k = 3; k < NS - 1; k++) begin
        if (z_r[k-1] >= 0) begin
          x_r[k] <= x_r[k-1] - (y_r[k-1] >>> (k - 3));
          y_r[k] <= y_r[k-1] + (x_r[k-1] >>> (k - 3));
          z_r[k] <= z_r[k-1] - atan_a(5'(k - 3));
        end else begin
          x_r[k] <= x_r[k-1] + (y_r[k-1] >>> (k - 3));
          y_r[k] <= y_r[k-1] - (x_r[k-1] >>> (k - 3));
          z_r[k] <= z_r[k-1] + atan_a(5'(k - 3));
        end
        neg_r[k] <= neg_r[k-1];
        th_r[k]  <= th_r[k-1];
      end
    end
  end

  // final stage: sign and rounding to the output format
  localparam int SH = ANG_BITS - FRAC_BITS;
  logic signed [35:0] xf, yf, xr, yr;
  always_comb begin
    xf = neg_r[NS-2] ? -x_r[NS-2] : x_r[NS-2];
    yf = neg_r[NS-2] ? -y_r[NS-2] : y_r[NS-2];
    xr = (xf + (36'sd1 <<< (SH - 1))) >>> SH;
    yr = (yf + (36'sd1 <<< (SH - 1))) >>> SH;
  end

  trig_t trig_r;
  always_ff @(posedge clk) begin
    if (en) begin
      trig_r.cs <= xr[31:0];
      trig_r.sn <= yr[31:0];
      trig_r.th <= th_r[NS-2];
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_trig = trig_r;

endmodule

FILE: rtl/tet_xform.sv
// pipelined rotation and translation assembly from sine, cosine and twist
`timescale 1ns / 1ps
module tet_xform
  import tet_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_vld,
  input  trig_t  in_trig,
  input  twist_t tw,
  output logic   out_vld,
  output q_t     rot [9],
  output q_t     trans [3]
);

  logic [5:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[4:0], in_vld};
  end
  assign out_vld = vld_r[5];

  q_t w [3];
  q_t v [3];
  assign w[0] = tw.wx; assign w[1] = tw.wy; assign w[2] = tw.wz;
  assign v[0] = tw.vx; assign v[1] = tw.vy; assign v[2] = tw.vz;
  logic zero_w;
  assign zero_w = (tw.wx == 0) && (tw.wy == 0) && (tw.wz == 0);

  // stage a: first products
  q_t ww_r [9];
  q_t ws_r [3];
  q_t wv_r [9];
  q_t vt_r, cs_a_r, th_a_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ww_r[i*3+j] <= mulq(w[i], w[j]);
          wv_r[i*3+j] <= mulq(w[i], v[j]);
        end
        ws_r[i] <= mulq(w[i], in_trig.sn);
      end
      vt_r   <= sat32(40'(ONE_Q) - 40'(in_trig.cs));
      cs_a_r <= in_trig.cs;
      th_a_r <= in_trig.th;
    end
  end

  // stage b: rotation, cross and dot products
  q_t r_b_r [9];
  q_t u_r [3];
  q_t d_r, th_b_r;
  always_ff @(posedge clk) begin
    if (en) begin
      r_b_r[0] <= sat32(40'(mulq(ww_r[0], vt_r)) + 40'(cs_a_r));
      r_b_r[1] <= sat32(40'(mulq(ww_r[1], vt_r)) - 40'(ws_r[2]));
      r_b_r[2] <= sat32(40'(mulq(ww_r[2], vt_r)) + 40'(ws_r[1]));
      r_b_r[3] <= sat32(40'(mulq(ww_r[3], vt_r)) + 40'(ws_r[2]));
      r_b_r[4] <= sat32(40'(mulq(ww_r[4], vt_r)) + 40'(cs_a_r));
      r_b_r[5] <= sat32(40'(mulq(ww_r[5], vt_r)) - 40'(ws_r[0]));
      r_b_r[6] <= sat32(40'(mulq(ww_r[6], vt_r)) - 40'(ws_r[1]));
      r_b_r[7] <= sat32(40'(mulq(ww_r[7], vt_r)) + 40'(ws_r[0]));
      r_b_r[8] <= sat32(40'(mulq(ww_r[8], vt_r)) + 40'(cs_a_r));
      u_r[0] <= sat32(40'(wv_r[5]) - 40'(wv_r[7]));
      u_r[1] <= sat32(40'(wv_r[6]) - 40'(wv_r[2]));
      u_r[2] <= sat32(40'(wv_r[1]) - 40'(wv_r[3]));
      d_r    <= sat32(40'(wv_r[0]) + 40'(wv_r[4]) + 40'(wv_r[8]));
      th_b_r <= th_a_r;
    end
  end

  // stage c: theta times dot, rotation times cross
  q_t dt_r, th_c_r;
  q_t ru_r [9];
  q_t r_c_r [9];
  q_t u_c_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      dt_r <= mulq(d_r, th_b_r);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          ru_r[i*3+j] <= mulq(r_b_r[i*3+j], u_r[j]);
      r_c_r  <= r_b_r;
      u_c_r  <= u_r;
      th_c_r <= th_b_r;
    end
  end

  // stage d: axis times theta-dot, translation sum
  q_t p_d_r [3];
  q_t r_d_r [9];
  q_t th_d_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        p_d_r[i] <= sat32(40'(u_c_r[i]) + 40'(mulq(w[i], dt_r)) - 40'(ru_r[i*3])
                          - 40'(ru_r[i*3+1]) - 40'(ru_r[i*3+2]));
      r_d_r  <= r_c_r;
      th_d_r <= th_c_r;
    end
  end

  // stage e: prismatic products
  q_t pv_r [3];
  q_t p_e_r [3];
  q_t r_e_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) pv_r[i] <= mulq(th_d_r, v[i]);
      p_e_r <= p_d_r;
      r_e_r <= r_d_r;
    end
  end

  // stage f: select revolute or prismatic result
  q_t rot_r [9];
  q_t trans_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++)
        rot_r[i] <= zero_w ? ((i % 4 == 0) ? ONE_Q : '0) : r_e_r[i];
      for (int i = 0; i < 3; i++)
        trans_r[i] <= zero_w ? pv_r[i] : p_e_r[i];
    end
  end
  assign rot = rot_r;
  assign trans = trans_r;

endmodule

FILE: rtl/twist_exponential_transform.sv
// top level: twist exponential of one joint as a rigid transform
`timescale 1ns / 1ps
// Usage: the axis w and linear part v are written through cfg_* while idle.
// Each in_ transaction carries a joint coordinate theta (Q16.16); each out_
// transaction carries the 3x3 rotation and translation of exp(xi_hat theta).
// There are 26 register stages: 20 in the cordic (turn count, remainder,
// fold, 16 rotations, rounding) and six product stages ending in the output
// register. One transaction enters per cycle while the receiver keeps up.
// The whole pipeline advances only when the output register is empty or
// being taken, so a stalled receiver holds every stage; in_tready drops
// then, nothing is lost or repeated.
// Synchronous active-low reset clears the configuration registers and all valid bits.
module twist_exponential_transform
  import tet_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_idx,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // joint_coord
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [383:0] out_tdata   // rot_00..rot_22, trans_x, trans_y, trans_z
);

  // configuration registers
  twist_t tw_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_W_X: tw_r.wx <= cfg_data;
        REG_W_Y: tw_r.wy <= cfg_data;
        REG_W_Z: tw_r.wz <= cfg_data;
        REG_V_X: tw_r.vx <= cfg_data;
        REG_V_Y: tw_r.vy <= cfg_data;
        REG_V_Z: tw_r.vz <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic c_vld, x_vld;
  trig_t trig;
  q_t rot [9];
  q_t trans [3];

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  tet_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_tvalid && in_tready), .theta(in_tdata),
    .out_vld(c_vld), .out_trig(trig)
  );

  tet_xform u_xform (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(c_vld), .in_trig(trig), .tw(tw_r),
    .out_vld(x_vld), .rot(rot), .trans(trans)
  );

  assign out_tvalid = x_vld;
  always_comb begin
    for (int i = 0; i < 9; i++) out_tdata[i*32 +: 32] = rot[i];
    for (int i = 0; i < 3; i++) out_tdata[(9+i)*32 +: 32] = trans[i];
  end

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped under stall");
  // input accepted exactly when pipeline moves
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("ready mismatch");
  // unit rot_00 of the identity rotation for a prismatic joint
  a_prism: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && $past(en) && $past(tw_r) == '0 && $stable(tw_r)
      |-> out_tdata[31:0] == ONE_Q)
    else $error("prismatic rotation wrong");

endmodule
